// ===== src/pfc_pkg.sv =====
// Package with the shared widths, transaction codes, edge token type and crossing test.
`default_nettype none
package pfc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int LAT_W        = 31;
    localparam int LON_W        = 32;
    localparam int PROD_W       = 64;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic                     active;
        logic                     parity;
        logic                     pend;
        logic                     dpos;
        logic signed [PROD_W-1:0] lhs;
        logic signed [PROD_W-1:0] rhs;
        logic signed [LAT_W-1:0]  qlat;
        logic signed [LON_W-1:0]  qlon;
        logic signed [LAT_W-1:0]  flat;
        logic signed [LON_W-1:0]  flon;
    } token_t;

    function automatic logic edge_east(input token_t tok);
        logic east;
        if (tok.dpos)
        begin
            east = $signed(tok.lhs) > $signed(tok.rhs);
        end
        else
        begin
            east = $signed(tok.lhs) < $signed(tok.rhs);
        end
        return tok.pend & east;
    endfunction

endpackage
`default_nettype wire

// ===== src/pfc_cell.sv =====
// One cell of the vertex chain: holds a vertex and evaluates the edge leaving it.
`default_nettype none
module pfc_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [pfc_pkg::CNT_W-1:0]         idx,
    input  wire logic [pfc_pkg::CNT_W-1:0]         count,
    input  wire logic                              wr_en,
    input  wire logic signed [pfc_pkg::LAT_W-1:0]  wr_lat,
    input  wire logic signed [pfc_pkg::LON_W-1:0]  wr_lon,
    input  wire logic signed [pfc_pkg::LAT_W-1:0]  nb_lat,
    input  wire logic signed [pfc_pkg::LON_W-1:0]  nb_lon,
    input  wire pfc_pkg::token_t                   tok_in,
    output pfc_pkg::token_t                        tok_out,
    output logic signed [pfc_pkg::LAT_W-1:0]       v_lat,
    output logic signed [pfc_pkg::LON_W-1:0]       v_lon
);

    logic signed [pfc_pkg::LAT_W-1:0]  lat_reg;
    logic signed [pfc_pkg::LON_W-1:0]  lon_reg;
    pfc_pkg::token_t                   tok_reg;
    pfc_pkg::token_t                   tok_next;

    logic                              closing;
    logic signed [pfc_pkg::LAT_W-1:0]  nlat;
    logic signed [pfc_pkg::LON_W-1:0]  nlon;
    logic signed [pfc_pkg::LAT_W:0]    dlat;
    logic signed [pfc_pkg::LAT_W:0]    dqlat;
    logic signed [pfc_pkg::LON_W:0]    dlon;
    logic signed [pfc_pkg::LON_W:0]    dqlon;
    logic signed [pfc_pkg::LAT_W+pfc_pkg::LON_W+1:0] lhs_full;
    logic signed [pfc_pkg::LAT_W+pfc_pkg::LON_W+1:0] rhs_full;
    logic                              in_span;
    logic                              edge_ok;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lat_reg <= wr_lat;
            lon_reg <= wr_lon;
        end
    end

    always_comb
    begin
        closing  = (idx + pfc_pkg::CNT_W'(1)) == count;
        nlat     = closing ? tok_in.flat : nb_lat;
        nlon     = closing ? tok_in.flon : nb_lon;
        dlat     = $signed({nlat[pfc_pkg::LAT_W-1], nlat})
                 - $signed({lat_reg[pfc_pkg::LAT_W-1], lat_reg});
        dqlat    = $signed({tok_in.qlat[pfc_pkg::LAT_W-1], tok_in.qlat})
                 - $signed({lat_reg[pfc_pkg::LAT_W-1], lat_reg});
        dlon     = $signed({nlon[pfc_pkg::LON_W-1], nlon})
                 - $signed({lon_reg[pfc_pkg::LON_W-1], lon_reg});
        dqlon    = $signed({tok_in.qlon[pfc_pkg::LON_W-1], tok_in.qlon})
                 - $signed({lon_reg[pfc_pkg::LON_W-1], lon_reg});
        lhs_full = dqlat * dlon;
        rhs_full = dqlon * dlat;
        in_span  = (tok_in.qlat > lat_reg && tok_in.qlat <= nlat)
                || (tok_in.qlat > nlat && tok_in.qlat <= lat_reg);
        edge_ok  = idx < count;

        tok_next        = tok_in;
        tok_next.parity = tok_in.parity ^ pfc_pkg::edge_east(tok_in);
        tok_next.pend   = tok_in.active & edge_ok & in_span;
        tok_next.dpos   = ~dlat[pfc_pkg::LAT_W];
        tok_next.lhs    = lhs_full[pfc_pkg::PROD_W-1:0];
        tok_next.rhs    = rhs_full[pfc_pkg::PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign v_lat   = lat_reg;
    assign v_lon   = lon_reg;

endmodule
`default_nettype wire

// ===== src/polygon_fence_containment.sv =====
// Top level of the polygon fence containment block: vertex chain, control and result register.
`default_nettype none
// A clear or append transaction needs no walk of the chain. A query transaction launches a token
// that walks the chain of MAX_VERTICES vertex cells at one cell per cycle, each cell testing
// the edge from its vertex to the next; the even-odd result is caught in the hold register
// when the token leaves the last cell, and the input is stalled until the result moves on to
// the output register. The output register lets further transactions through while a
// result waits to be taken.
module polygon_fence_containment (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        kind,
    input  wire logic signed [pfc_pkg::LAT_W-1:0]  lat,
    input  wire logic signed [pfc_pkg::LON_W-1:0]  lon,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   inside_res,
    output logic [pfc_pkg::CNT_W-1:0]              vertex_total
);

    localparam int N = pfc_pkg::MAX_VERTICES;

    logic [pfc_pkg::CNT_W-1:0] count_reg;
    logic [pfc_pkg::CNT_W-1:0] count_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      hold_valid_reg;
    logic                      hold_valid_next;
    logic                      hold_inside_reg;
    logic                      hold_inside_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      inside_res_reg;
    logic [pfc_pkg::CNT_W-1:0] vertex_total_reg;

    logic                      accept;
    logic                      append;
    logic                      load_out;
    logic                      finish;

    pfc_pkg::token_t                  tok [0:N];
    logic signed [pfc_pkg::LAT_W-1:0] v_lat [0:N-1];
    logic signed [pfc_pkg::LON_W-1:0] v_lon [0:N-1];

    assign in_stall = busy_reg;
    assign accept   = in_valid & ~busy_reg;
    assign append   = accept && kind == pfc_pkg::KIND_APPEND
                   && count_reg < pfc_pkg::CNT_W'(N);

    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = accept && kind == pfc_pkg::KIND_QUERY;
        tok[0].qlat   = lat;
        tok[0].qlon   = lon;
        tok[0].flat   = v_lat[0];
        tok[0].flon   = v_lon[0];
    end

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            pfc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (pfc_pkg::CNT_W'(k)),
                .count   (count_reg),
                .wr_en   (append && count_reg == pfc_pkg::CNT_W'(k)),
                .wr_lat  (lat),
                .wr_lon  (lon),
                .nb_lat  (v_lat[(k + 1) % N]),
                .nb_lon  (v_lon[(k + 1) % N]),
                .tok_in  (tok[k]),
                .tok_out (tok[k + 1]),
                .v_lat   (v_lat[k]),
                .v_lon   (v_lon[k])
            );
        end
    endgenerate

    assign finish   = tok[N].active;
    assign load_out = hold_valid_reg & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        count_next = count_reg;
        if (accept && kind == pfc_pkg::KIND_CLEAR)
        begin
            count_next = '0;
        end
        else if (append)
        begin
            count_next = count_reg + pfc_pkg::CNT_W'(1);
        end

        busy_next = busy_reg;
        if (accept && kind == pfc_pkg::KIND_QUERY)
        begin
            busy_next = 1'b1;
        end
        else if (load_out)
        begin
            busy_next = 1'b0;
        end

        hold_valid_next  = hold_valid_reg;
        hold_inside_next = hold_inside_reg;
        if (finish)
        begin
            hold_valid_next  = 1'b1;
            hold_inside_next = tok[N].parity ^ pfc_pkg::edge_east(tok[N]);
        end
        else if (load_out)
        begin
            hold_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            busy_reg       <= busy_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_inside_reg <= hold_inside_next;
        if (load_out)
        begin
            inside_res_reg   <= hold_inside_reg;
            vertex_total_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign inside_res   = inside_res_reg;
    assign vertex_total = vertex_total_reg;

    a_hold_busy : assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> busy_reg)
        else $error("Result held while no query is in flight.");

    a_token_busy : assert property (@(posedge clk) disable iff (!rst_n)
        tok[N].active |-> busy_reg && !hold_valid_reg)
        else $error("Query token finished outside a query transaction.");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pfc_pkg::CNT_W'(N))
        else $error("Vertex count exceeds the table depth.");

endmodule
`default_nettype wire
